>>> hw/rtl/aftkf_pkg.sv
package aftkf_pkg;

   localparam int unsigned CFG_INDEX_BITS = 3;
   localparam int unsigned CFG_DATA_BITS = 32;

   typedef enum logic [CFG_INDEX_BITS-1:0] {
      CSR_TARGET_STI = 3'd0,
      CSR_TARGET_LTI = 3'd1,
      CSR_BUFFER_STI = 3'd2,
      CSR_BUFFER_LTI = 3'd3,
      CSR_WAGE_STI   = 3'd4,
      CSR_WAGE_LTI   = 3'd5,
      CSR_FOCUS_SIZE = 3'd6
   } csr_index_type;

   localparam logic REQ_SET = 1'b0;
   localparam logic REQ_STIMULATE = 1'b1;

   // Wage divider: quotient width covers base*(2*buffer) / buffer < 2^15.
   localparam int unsigned DIV_NUM_BITS = 46;
   localparam int unsigned DIV_DEN_BITS = 31;
   localparam int unsigned DIV_STEP_BITS = 6;

   typedef struct packed {
      logic start;
      logic [DIV_NUM_BITS-1:0] numerator;
      logic [DIV_DEN_BITS-1:0] denominator;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DIV_NUM_BITS-1:0] quotient;
   } div_rsp_type;

endpackage

>>> hw/rtl/aftkf_stream_if.sv
interface aftkf_stream_if #(
   parameter int unsigned PAYLOAD_BITS = 1
);
   logic valid;
   logic ready;
   logic [PAYLOAD_BITS-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

>>> hw/rtl/aftkf_divider.sv
// Restoring divider, one quotient bit per cycle.
module aftkf_divider (
   input  logic clock,
   input  logic reset,
   input  aftkf_pkg::div_req_type div_req,
   output aftkf_pkg::div_rsp_type div_rsp
);
   localparam int unsigned NB = aftkf_pkg::DIV_NUM_BITS;
   localparam int unsigned DB = aftkf_pkg::DIV_DEN_BITS;
   localparam int unsigned SB = aftkf_pkg::DIV_STEP_BITS;

   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [SB-1:0] step_ff, step_in;
   logic [NB-1:0] quo_ff, quo_in;
   logic [DB:0] rem_ff, rem_in;
   logic [DB-1:0] den_ff, den_in;
   logic [DB+1:0] trial;
   logic [DB:0] shifted;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      den_in = den_ff;
      shifted = {rem_ff[DB-1:0], quo_ff[NB-1]};
      trial = {1'b0, shifted} - {2'b00, den_ff};
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = SB'(NB - 1);
         quo_in = div_req.numerator;
         rem_in = '0;
         den_in = div_req.denominator;
      end else if (busy_ff) begin
         if (!trial[DB+1]) begin
            rem_in = trial[DB:0];
            quo_in = {quo_ff[NB-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[NB-2:0], 1'b0};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule

>>> hw/rtl/attention_funds_top_k_focus_core.sv
// From the input transfer to a valid result: two wage divides (sti, then lti) on the
// shared divider, one state to apply the stimulus, a search of the whole table and one
// update state. Input is not ready again until the result transfer is done.
// Synchronous active-high reset clears control and valid bits and loads the funds and
// configuration registers with their starting values.
module attention_funds_top_k_focus_core #(
   parameter int unsigned FOCUS_DEPTH = 128,
   parameter int unsigned HANDLE_BITS = 32,
   parameter int unsigned STARTING_FUNDS = 100000
) (
   input  logic clock,
   input  logic reset,
   aftkf_stream_if.sink req_chan,
   aftkf_stream_if.source rsp_chan,
   input  logic csr_write_enable,
   input  logic [aftkf_pkg::CFG_INDEX_BITS-1:0] csr_index,
   input  logic [aftkf_pkg::CFG_DATA_BITS-1:0] csr_write_data
);
   localparam int unsigned AB = (FOCUS_DEPTH > 1) ? $clog2(FOCUS_DEPTH) : 1;
   localparam int unsigned CB = $clog2(FOCUS_DEPTH + 1);
   localparam int unsigned NB = aftkf_pkg::DIV_NUM_BITS;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_DIVS  = 9'b000000010,
      ST_WAITS = 9'b000000100,
      ST_DIVL  = 9'b000001000,
      ST_WAITL = 9'b000010000,
      ST_APPLY = 9'b000100000,
      ST_SCAN  = 9'b001000000,
      ST_UPD   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   // Input payload fields.
   logic req_type_w;
   logic [31:0] atom_handle_w;
   logic signed [15:0] old_sti_w, old_lti_w, new_sti_w, new_lti_w, stimulus_w;
   assign {req_type_w, atom_handle_w, old_sti_w, old_lti_w, new_sti_w, new_lti_w,
           stimulus_w} = req_chan.payload;

   logic signed [31:0] tgt_sti_ff, tgt_lti_ff;
   logic [30:0] buf_sti_ff, buf_lti_ff;
   logic [13:0] wage_sti_ff, wage_lti_ff;
   logic [7:0] fsize_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tgt_sti_ff <= 32'sd10000;
         tgt_lti_ff <= 32'sd10000;
         buf_sti_ff <= 31'd10000;
         buf_lti_ff <= 31'd10000;
         wage_sti_ff <= 14'd10;
         wage_lti_ff <= 14'd10;
         fsize_ff <= 8'd100;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            aftkf_pkg::CSR_TARGET_STI: tgt_sti_ff <= csr_write_data;
            aftkf_pkg::CSR_TARGET_LTI: tgt_lti_ff <= csr_write_data;
            aftkf_pkg::CSR_BUFFER_STI: buf_sti_ff <= csr_write_data[30:0];
            aftkf_pkg::CSR_BUFFER_LTI: buf_lti_ff <= csr_write_data[30:0];
            aftkf_pkg::CSR_WAGE_STI: wage_sti_ff <= csr_write_data[13:0];
            aftkf_pkg::CSR_WAGE_LTI: wage_lti_ff <= csr_write_data[13:0];
            aftkf_pkg::CSR_FOCUS_SIZE: fsize_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   state_type state_ff, state_in;
   logic signed [31:0] fund_sti_ff, fund_lti_ff;
   logic stim_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic signed [15:0] old_sti_ff, old_lti_ff, new_sti_ff, new_lti_ff, stim_val_ff;
   logic [14:0] ws_ff, wl_ff;
   logic signed [15:0] res_sti_ff, res_lti_ff;

   // Wage setup for the selected channel (lti while in ST_DIVL or ST_WAITL, else sti).
   logic sel_lti;
   logic signed [32:0] diff;
   logic [30:0] bsel;
   logic [31:0] beff;
   logic [13:0] base_sel;
   logic wage_hi, wage_lo;
   logic [32:0] bplusd;
   logic [NB-1:0] prod_num;
   assign sel_lti = (state_ff == ST_DIVL) || (state_ff == ST_WAITL);
   always_comb begin
      bsel = sel_lti ? buf_lti_ff : buf_sti_ff;
      beff = (bsel == '0) ? 32'd1 : {1'b0, bsel};
      base_sel = sel_lti ? wage_lti_ff : wage_sti_ff;
      diff = sel_lti ? (33'(fund_lti_ff) - 33'(tgt_lti_ff))
                     : (33'(fund_sti_ff) - 33'(tgt_sti_ff));
      wage_hi = diff >= $signed({1'b0, beff});
      wage_lo = diff <= -$signed({1'b0, beff});
      bplusd = 33'($signed({1'b0, beff}) + diff);
      prod_num = NB'(base_sel) * NB'(bplusd[31:0]);
   end

   aftkf_pkg::div_req_type div_req;
   aftkf_pkg::div_rsp_type div_rsp;
   assign div_req.start = (state_ff == ST_DIVS) || (state_ff == ST_DIVL);
   assign div_req.numerator = prod_num;
   assign div_req.denominator = beff[30:0];
   aftkf_divider u_div (.clock, .reset, .div_req, .div_rsp);

   logic [14:0] wage_now;
   assign wage_now = wage_hi ? {base_sel, 1'b0} : (wage_lo ? 15'd0 : div_rsp.quotient[14:0]);

   // Stimulation arithmetic.
   function automatic logic signed [15:0] stim_apply(input logic signed [15:0] old,
                                                     input logic [14:0] wage,
                                                     input logic signed [15:0] stim);
      logic signed [31:0] p;
      logic [31:0] m;
      logic signed [32:0] s;
      begin
         p = $signed({1'b0, wage}) * stim;
         m = (p < 0) ? 32'(-p) : 32'(p);
         m = m >> 8;
         s = (p < 0) ? (33'(old) - $signed({1'b0, m})) : (33'(old) + $signed({1'b0, m}));
         stim_apply = (s > 33'sd32767) ? 16'sh7fff : ((s < -33'sd32768) ? 16'sh8000 : s[15:0]);
      end
   endfunction

   function automatic logic signed [31:0] fund_add(input logic signed [31:0] f,
                                                   input logic signed [15:0] o,
                                                   input logic signed [15:0] r);
      logic signed [33:0] s;
      begin
         s = 34'(f) + 34'(o) - 34'(r);
         fund_add = (s > 34'sh07fffffff) ? 32'sh7fffffff :
                    ((s < -34'sh080000000) ? 32'sh80000000 : s[31:0]);
      end
   endfunction

   // Focus table: memories with a registered read port, valid bits in flops.
   logic [HANDLE_BITS-1:0] mem_handle [FOCUS_DEPTH];
   logic signed [15:0] mem_value [FOCUS_DEPTH];
   logic [FOCUS_DEPTH-1:0] valid_ff;
   logic [AB-1:0] raddr;
   logic [HANDLE_BITS-1:0] rd_handle_ff;
   logic signed [15:0] rd_value_ff;
   logic mem_we;
   logic [AB-1:0] waddr;
   logic [HANDLE_BITS-1:0] wdata_h;

   logic [CB-1:0] scan_ff;  // address being read
   logic rd_live_ff;
   logic [AB-1:0] rd_idx_ff;
   logic hit_ff, free_found_ff, low_found_ff;
   logic [AB-1:0] hit_idx_ff, free_idx_ff, low_idx_ff;
   logic signed [15:0] low_val_ff;
   logic [HANDLE_BITS-1:0] low_handle_ff;
   logic [CB-1:0] count_ff;

   assign raddr = scan_ff[AB-1:0];

   always_ff @(posedge clock) begin
      rd_handle_ff <= mem_handle[raddr];
      rd_value_ff <= mem_value[raddr];
      if (mem_we) begin
         mem_handle[waddr] <= wdata_h;
         mem_value[waddr] <= res_sti_ff;
      end
   end

   // Update decision.
   logic [CB-1:0] cap;
   logic do_hit, do_add, do_evict;
   always_comb begin
      cap = (fsize_ff > 8'(FOCUS_DEPTH) || FOCUS_DEPTH > 255) ?
            ((32'(fsize_ff) > FOCUS_DEPTH) ? CB'(FOCUS_DEPTH) : CB'(fsize_ff)) : CB'(fsize_ff);
      do_hit = hit_ff;
      do_add = !hit_ff && (count_ff < cap) && free_found_ff;
      do_evict = !hit_ff && !do_add && low_found_ff && (res_sti_ff > low_val_ff);
      mem_we = (state_ff == ST_UPD) && (do_hit || do_add || do_evict);
      waddr = do_hit ? hit_idx_ff : (do_add ? free_idx_ff : low_idx_ff);
      wdata_h = handle_ff;
   end

   // Output register.
   logic rsp_valid_ff;
   logic [15:0] o_sti_ff, o_lti_ff, o_ev_sti_ff;
   logic o_present_ff, o_added_ff, o_evicted_ff;
   logic [31:0] o_ev_handle_ff;

   logic handle_eq;
   logic rd_valid;
   assign rd_valid = valid_ff[rd_idx_ff];
   assign handle_eq = rd_handle_ff == handle_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_chan.valid) state_in = ST_DIVS;
         ST_DIVS: state_in = ST_WAITS;
         ST_WAITS: if (div_rsp.done) state_in = ST_DIVL;
         ST_DIVL: state_in = ST_WAITL;
         ST_WAITL: if (div_rsp.done) state_in = ST_APPLY;
         ST_APPLY: state_in = ST_SCAN;
         ST_SCAN: if (!rd_live_ff && scan_ff == CB'(FOCUS_DEPTH)) state_in = ST_UPD;
         ST_UPD: state_in = ST_OUT;
         ST_OUT: if (!rsp_valid_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_chan.ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fund_sti_ff <= 32'(STARTING_FUNDS);
         fund_lti_ff <= 32'(STARTING_FUNDS);
         valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         rd_live_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_valid_ff && rsp_chan.ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: if (req_chan.valid) begin
               stim_ff <= req_type_w == aftkf_pkg::REQ_STIMULATE;
               handle_ff <= HANDLE_BITS'(atom_handle_w);
               old_sti_ff <= old_sti_w;
               old_lti_ff <= old_lti_w;
               new_sti_ff <= new_sti_w;
               new_lti_ff <= new_lti_w;
               stim_val_ff <= stimulus_w;
            end
            ST_WAITS: if (div_rsp.done) ws_ff <= wage_now;
            ST_WAITL: if (div_rsp.done) wl_ff <= wage_now;
            ST_APPLY: begin
               if (stim_ff) begin
                  res_sti_ff <= stim_apply(old_sti_ff, ws_ff, stim_val_ff);
                  res_lti_ff <= stim_apply(old_lti_ff, wl_ff, stim_val_ff);
               end else begin
                  res_sti_ff <= new_sti_ff;
                  res_lti_ff <= new_lti_ff;
               end
               scan_ff <= '0;
               rd_live_ff <= 1'b0;
               hit_ff <= 1'b0;
               free_found_ff <= 1'b0;
               low_found_ff <= 1'b0;
               count_ff <= '0;
            end
            ST_SCAN: begin
               if (scan_ff != CB'(FOCUS_DEPTH)) begin
                  rd_live_ff <= 1'b1;
                  rd_idx_ff <= raddr;
                  scan_ff <= scan_ff + 1'b1;
               end else begin
                  rd_live_ff <= 1'b0;
               end
               if (rd_live_ff) begin
                  if (rd_valid) begin
                     count_ff <= count_ff + 1'b1;
                     if (!hit_ff && handle_eq) begin
                        hit_ff <= 1'b1;
                        hit_idx_ff <= rd_idx_ff;
                     end
                     if (!low_found_ff || rd_value_ff < low_val_ff) begin
                        low_found_ff <= 1'b1;
                        low_idx_ff <= rd_idx_ff;
                        low_val_ff <= rd_value_ff;
                        low_handle_ff <= rd_handle_ff;
                     end
                  end else if (!free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff <= rd_idx_ff;
                  end
               end
            end
            ST_UPD: begin
               fund_sti_ff <= fund_add(fund_sti_ff, old_sti_ff, res_sti_ff);
               fund_lti_ff <= fund_add(fund_lti_ff, old_lti_ff, res_lti_ff);
               if (do_add) valid_ff[free_idx_ff] <= 1'b1;
               o_sti_ff <= res_sti_ff;
               o_lti_ff <= res_lti_ff;
               o_present_ff <= do_hit;
               o_added_ff <= do_add || do_evict;
               o_evicted_ff <= do_evict;
               o_ev_handle_ff <= do_evict ? 32'(low_handle_ff) : 32'd0;
               o_ev_sti_ff <= do_evict ? low_val_ff : 16'd0;
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.payload = {o_sti_ff, o_lti_ff, o_present_ff, o_added_ff, o_evicted_ff,
                              o_ev_handle_ff, o_ev_sti_ff, fund_sti_ff, fund_lti_ff};
endmodule

>>> verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic req_type;
      logic [31:0] atom_handle;
      logic signed [15:0] old_sti;
      logic signed [15:0] old_lti;
      logic signed [15:0] new_sti;
      logic signed [15:0] new_lti;
      logic signed [15:0] stimulus;
   } focus_req_type;

   typedef struct packed {
      logic signed [15:0] result_sti;
      logic signed [15:0] result_lti;
      logic was_present;
      logic added;
      logic evicted;
      logic [31:0] evicted_handle;
      logic signed [15:0] evicted_sti;
      logic signed [31:0] sti_funds;
      logic signed [31:0] lti_funds;
   } focus_rsp_type;

   localparam int TABLE_DEPTH = 128;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [aftkf_pkg::CFG_INDEX_BITS-1:0] csr_index = '0;
   logic [aftkf_pkg::CFG_DATA_BITS-1:0] csr_write_data = '0;

   aftkf_stream_if #(.PAYLOAD_BITS($bits(focus_req_type))) req_chan ();
   aftkf_stream_if #(.PAYLOAD_BITS($bits(focus_rsp_type))) rsp_chan ();

   attention_funds_top_k_focus_core uut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mirror of the configuration and of the block's state.
   longint target_sti, target_lti, sti_level, lti_level;
   longint unsigned buffer_sti, buffer_lti, wage_sti, wage_lti, capacity;
   logic [31:0] slot_handle [TABLE_DEPTH];
   longint slot_value [TABLE_DEPTH];
   bit slot_used [TABLE_DEPTH];

   focus_rsp_type pending_rsp [$];
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_cycles = 0;
   int error_count = 0;
   int items_sent = 0;
   int rsp_seen = 0;
   int evictions_seen = 0;
   int hits_seen = 0;

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint wage_for(longint level, longint target,
                                       longint unsigned buf_size, longint unsigned base);
      longint diff;
      longint b;
      diff = level - target;
      b = buf_size == 0 ? 1 : longint'(buf_size);
      if (diff >= b) return 2 * longint'(base);
      if (diff <= -b) return 0;
      return (longint'(base) * (b + diff)) / b;
   endfunction

   function automatic longint apply_stimulus(longint old_val, longint wage, longint stim);
      longint p;
      longint m;
      p = wage * stim;
      m = (p < 0 ? -p : p) / 256;
      return clamp(old_val + (p < 0 ? -m : m), -32768, 32767);
   endfunction

   function automatic focus_rsp_type predict_focus(focus_req_type r);
      focus_rsp_type e;
      longint s_val, l_val, cap;
      int hit, free_slot, low, used;
      hit = -1;
      free_slot = -1;
      low = -1;
      used = 0;
      if (r.req_type == aftkf_pkg::REQ_STIMULATE) begin
         s_val = apply_stimulus(r.old_sti,
                                wage_for(sti_level, target_sti, buffer_sti, wage_sti),
                                r.stimulus);
         l_val = apply_stimulus(r.old_lti,
                                wage_for(lti_level, target_lti, buffer_lti, wage_lti),
                                r.stimulus);
      end else begin
         s_val = r.new_sti;
         l_val = r.new_lti;
      end
      sti_level = clamp(sti_level + (longint'(r.old_sti) - s_val), -(64'sd1 <<< 31),
                        (64'sd1 <<< 31) - 1);
      lti_level = clamp(lti_level + (longint'(r.old_lti) - l_val), -(64'sd1 <<< 31),
                        (64'sd1 <<< 31) - 1);
      e = '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_used[i]) begin
            used++;
            if (hit < 0 && slot_handle[i] == r.atom_handle) hit = i;
            if (low < 0 || slot_value[i] < slot_value[low]) low = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      cap = capacity > TABLE_DEPTH ? TABLE_DEPTH : capacity;
      if (hit >= 0) begin
         slot_value[hit] = s_val;
         e.was_present = 1'b1;
      end else if (used < cap && free_slot >= 0) begin
         slot_used[free_slot] = 1'b1;
         slot_handle[free_slot] = r.atom_handle;
         slot_value[free_slot] = s_val;
         e.added = 1'b1;
      end else if (low >= 0 && s_val > slot_value[low]) begin
         e.evicted = 1'b1;
         e.added = 1'b1;
         e.evicted_handle = slot_handle[low];
         e.evicted_sti = 16'(slot_value[low]);
         slot_handle[low] = r.atom_handle;
         slot_value[low] = s_val;
      end
      e.result_sti = 16'(s_val);
      e.result_lti = 16'(l_val);
      e.sti_funds = 32'(sti_level);
      e.lti_funds = 32'(lti_level);
      return e;
   endfunction

   task automatic send_item(input focus_req_type r);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.payload <= r;
      do @(posedge clock); while (!req_chan.ready);
      pending_rsp.push_back(predict_focus(r));
      items_sent++;
   endtask

   task automatic drain;
      req_chan.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_csr(input aftkf_pkg::csr_index_type idx, input logic [31:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         aftkf_pkg::CSR_TARGET_STI: target_sti = longint'(signed'(data));
         aftkf_pkg::CSR_TARGET_LTI: target_lti = longint'(signed'(data));
         aftkf_pkg::CSR_BUFFER_STI: buffer_sti = data[30:0];
         aftkf_pkg::CSR_BUFFER_LTI: buffer_lti = data[30:0];
         aftkf_pkg::CSR_WAGE_STI: wage_sti = data[13:0];
         aftkf_pkg::CSR_WAGE_LTI: wage_lti = data[13:0];
         aftkf_pkg::CSR_FOCUS_SIZE: capacity = data[7:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] t_sti, t_lti, b_sti, b_lti, w_sti, w_lti,
                            input logic [31:0] fsize);
      write_csr(aftkf_pkg::CSR_TARGET_STI, t_sti);
      write_csr(aftkf_pkg::CSR_TARGET_LTI, t_lti);
      write_csr(aftkf_pkg::CSR_BUFFER_STI, b_sti);
      write_csr(aftkf_pkg::CSR_BUFFER_LTI, b_lti);
      write_csr(aftkf_pkg::CSR_WAGE_STI, w_sti);
      write_csr(aftkf_pkg::CSR_WAGE_LTI, w_lti);
      write_csr(aftkf_pkg::CSR_FOCUS_SIZE, fsize);
   endtask

   function automatic focus_req_type make_item(logic kind, logic [31:0] handle,
                                               int o_s, int o_l, int n_s, int n_l, int stim);
      focus_req_type r;
      r.req_type = kind;
      r.atom_handle = handle;
      r.old_sti = 16'(o_s);
      r.old_lti = 16'(o_l);
      r.new_sti = 16'(n_s);
      r.new_lti = 16'(n_l);
      r.stimulus = 16'(stim);
      return r;
   endfunction

   function automatic focus_req_type random_item(int handle_pool);
      focus_req_type r;
      r = make_item($urandom_range(0, 1), 0, $urandom, $urandom, $urandom, $urandom,
                    $urandom);
      // Mostly reuse a small set of handles so that refreshes and evictions happen.
      if ($urandom_range(0, 9) == 0) r.atom_handle = $urandom;
      else r.atom_handle = $urandom_range(0, handle_pool - 1);
      return r;
   endfunction

   // Result side: check each transfer and drive ready for the next edge.
   always @(posedge clock) begin
      focus_rsp_type got;
      focus_rsp_type e;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = rsp_chan.payload;
            rsp_seen++;
            if (pending_rsp.size() == 0) begin
               $error("result with nothing expected: %h", got);
               error_count++;
            end else begin
               e = pending_rsp.pop_front();
               if (e.evicted) evictions_seen++;
               if (e.was_present) hits_seen++;
               if (got.result_sti !== e.result_sti) begin
                  $error("result_sti expected %0d got %0d", e.result_sti, got.result_sti);
                  error_count++;
               end
               if (got.result_lti !== e.result_lti) begin
                  $error("result_lti expected %0d got %0d", e.result_lti, got.result_lti);
                  error_count++;
               end
               if (got.was_present !== e.was_present) begin
                  $error("was_present expected %0d got %0d", e.was_present, got.was_present);
                  error_count++;
               end
               if (got.added !== e.added) begin
                  $error("added expected %0d got %0d", e.added, got.added);
                  error_count++;
               end
               if (got.evicted !== e.evicted) begin
                  $error("evicted expected %0d got %0d", e.evicted, got.evicted);
                  error_count++;
               end
               if (got.evicted_handle !== e.evicted_handle) begin
                  $error("evicted_handle expected %h got %h", e.evicted_handle,
                         got.evicted_handle);
                  error_count++;
               end
               if (got.evicted_sti !== e.evicted_sti) begin
                  $error("evicted_sti expected %0d got %0d", e.evicted_sti, got.evicted_sti);
                  error_count++;
               end
               if (got.sti_funds !== e.sti_funds) begin
                  $error("sti_funds expected %0d got %0d", e.sti_funds, got.sti_funds);
                  error_count++;
               end
               if (got.lti_funds !== e.lti_funds) begin
                  $error("lti_funds expected %0d got %0d", e.lti_funds, got.lti_funds);
                  error_count++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // Watchdog on cycles without any transfer.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic test_set_and_table;
      // Small table: fill, refresh, tie on lowest, eviction and rejection.
      configure(10000, 10000, 10000, 10000, 10, 10, 2);
      send_item(make_item(aftkf_pkg::REQ_SET, 32'h0000_0000, 0, 0, 5, -32768, 0));
      send_item(make_item(aftkf_pkg::REQ_SET, 32'hFFFF_FFFF, 32767, -32768, 5, 32767,
                          -32768));
      send_item(make_item(aftkf_pkg::REQ_SET, 32'h0000_0000, 0, 0, 7, 0, 32767));
      send_item(make_item(aftkf_pkg::REQ_SET, 32'h1234_5678, 0, 0, 6, 0, 0));
      send_item(make_item(aftkf_pkg::REQ_SET, 32'h0000_0042, 0, 0, -32768, 0, 0));
      send_item(make_item(aftkf_pkg::REQ_SET, 32'h0000_0043, -32768, 32767, 32767, -32768,
                          0));
      drain();
      // A capacity of zero on a nonempty table still lets an atom replace the lowest.
      configure(10000, 10000, 10000, 10000, 10, 10, 0);
      send_item(make_item(aftkf_pkg::REQ_SET, 32'h0000_0044, 0, 0, 32767, 0, 0));
      send_item(make_item(aftkf_pkg::REQ_SET, 32'h0000_0045, 0, 0, -5, 0, 0));
      drain();
   endtask

   task automatic test_stimulate_wages;
      // Zero buffers count as one; a target at the low extreme forces the upper wage limit.
      configure(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 16383, 16383, 200);
      send_item(make_item(aftkf_pkg::REQ_STIMULATE, 32'h0000_0100, 0, 0, 0, 0, 32767));
      send_item(make_item(aftkf_pkg::REQ_STIMULATE, 32'h0000_0101, 32767, -32768, 0, 0,
                          -32768));
      send_item(make_item(aftkf_pkg::REQ_STIMULATE, 32'h0000_0102, -32768, 32767, 0, 0, 1));
      send_item(make_item(aftkf_pkg::REQ_STIMULATE, 32'h0000_0103, 100, -100, 0, 0, -1));
      drain();
      configure(100000, -100000, 32'h7FFF_FFFF, 0, 0, 16383, 128);
      send_item(make_item(aftkf_pkg::REQ_STIMULATE, 32'h0000_0104, 10, 10, 0, 0, 32767));
      send_item(make_item(aftkf_pkg::REQ_STIMULATE, 32'h0000_0104, -32768, 0, 0, 0, -32768));
      send_item(make_item(aftkf_pkg::REQ_STIMULATE, 32'h0000_0105, 0, 0, 1234, 4321, 256));
      drain();
   endtask

   task automatic test_random_phase(input int count, input int tx_pct, input int rx_pct);
      int pool;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      for (int i = 0; i < count; i++) begin
         if (i % 80 == 0) begin
            drain();
            pool = $urandom_range(0, 3) == 0 ? 300 : 40;
            configure($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(90000, 110000),
                      $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(90000, 110000),
                      $urandom_range(0, 1) ? $urandom_range(0, 20000) : $urandom,
                      $urandom_range(0, 1) ? $urandom_range(0, 20000) : $urandom,
                      $urandom_range(0, 16383), $urandom_range(0, 16383),
                      $urandom_range(0, 2) == 0 ? $urandom_range(0, 255)
                                                : $urandom_range(1, 12));
         end
         send_item(random_item(pool));
      end
      drain();
   endtask

   task automatic test_backpressure;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      hold_cycles = 1500;
      for (int i = 0; i < 10; i++) send_item(random_item(20));
      drain();
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      target_sti = 10000;
      target_lti = 10000;
      buffer_sti = 10000;
      buffer_lti = 10000;
      wage_sti = 10;
      wage_lti = 10;
      capacity = 100;
      sti_level = 100000;
      lti_level = 100000;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         slot_used[i] = 1'b0;
         slot_handle[i] = '0;
         slot_value[i] = 0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration is exercised first.
      send_item(make_item(aftkf_pkg::REQ_STIMULATE, 32'h0000_0007, 50, 50, 0, 0, 512));
      drain();
      test_set_and_table();
      test_stimulate_wages();
      test_random_phase(310, 12, 85);
      test_random_phase(310, 85, 12);
      test_backpressure();
      test_random_phase(310, 0, 0);

      repeat (300) @(posedge clock);
      $display("Covered %0d items: set and stimulate requests across %0s",
               items_sent, "wage extremes, table sizes and stalls on both sides.");
      $display("Results checked %0d, refreshes %0d, evictions %0d.",
               rsp_seen, hits_seen, evictions_seen);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
